// ===== src/bspm_pkg.sv =====
`timescale 1ns / 1ps
// Package for the buffer slot pin manager: sizes, field widths, codes and word formats.
// No dependencies; every other file of the block imports it.
package bspm_pkg;

    localparam int MAX_TIPS  = 1024;
    localparam int MAX_SLOTS = 256;
    localparam int NODE_AW   = $clog2(MAX_TIPS);
    localparam int SLOT_AW   = $clog2(MAX_SLOTS);
    localparam int MAP_W     = SLOT_AW + 1;

    localparam int TIPS_W  = 11;
    localparam int SLOTS_W = 9;
    localparam int COST_W  = 10;
    localparam int KIND_W  = 3;
    localparam int NODE_W  = 11;
    localparam int SLOT_W  = 8;
    localparam int CFG_IW  = 2;
    localparam int CFG_DW  = 11;
    localparam int BEST_W  = TIPS_W + 1;

    localparam int SWEEP_N = (MAX_TIPS > MAX_SLOTS) ? MAX_TIPS : MAX_SLOTS;
    localparam int SWEEP_W = $clog2(SWEEP_N + 1);

    localparam logic [COST_W-1:0] CHEAPEST_COST = COST_W'(2);
    localparam logic [COST_W-1:0] COST_UNSET    = '0;

    typedef enum logic [KIND_W-1:0] {
        KIND_ACQUIRE = 3'd0,
        KIND_RELEASE = 3'd1,
        KIND_SETCOST = 3'd2,
        KIND_CLRCOST = 3'd3,
        KIND_UNPIN   = 3'd4,
        KIND_SAVE    = 3'd5,
        KIND_RESTORE = 3'd6,
        KIND_QUERY   = 3'd7
    } t_kind;

    typedef enum logic [CFG_IW-1:0] {
        CFG_NUM_TIPS  = 2'd0,
        CFG_NUM_SLOTS = 2'd1,
        CFG_SNAP_EN   = 2'd2
    } t_cfg_reg;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_SWEEP,
        ST_NODE_CHK,
        ST_SLOT_WR,
        ST_FREE,
        ST_EVICT,
        ST_VIC_RD,
        ST_VIC_WR,
        ST_PIN,
        ST_UP_RD,
        ST_UP_OWN,
        ST_UP_NODE,
        ST_DONE
    } t_state;

    typedef enum logic [1:0] {
        SW_INIT,
        SW_CLRCOST,
        SW_SAVE,
        SW_RESTORE
    } t_sweep_op;

    typedef struct packed {
        logic [KIND_W-1:0] kind;
        logic [NODE_W-1:0] node;
        logic [COST_W-1:0] cost;
    } t_item;

    typedef struct packed {
        logic [SLOT_W-1:0] slot;
        logic              needs_recompute;
        logic              is_pinned;
        logic              evicted;
        logic [NODE_W-1:0] evicted_node;
        logic [SLOT_W-1:0] max_slot_used;
        logic              error;
    } t_result;

    typedef struct packed {
        logic               unpinned;
        logic [SLOT_AW-1:0] slot;
    } t_map;

    localparam t_map MAP_NONE = '{unpinned: 1'b1, slot: '0};

    typedef struct packed {
        t_map              shadow_map;
        logic [COST_W-1:0] cost;
        t_map              map;
    } t_node_word;

    typedef struct packed {
        logic               sh_rel;
        logic               sh_valid;
        logic [NODE_AW-1:0] sh_owner;
        logic               rel;
        logic               valid;
        logic [NODE_AW-1:0] owner;
    } t_slot_word;

endpackage

// ===== src/bspm_ifs.sv =====
`timescale 1ns / 1ps
// Valid/ready channel interfaces of the pin manager: request, result and register write.
// Depends on bspm_pkg for the payload types.
interface bspm_item_if;
    import bspm_pkg::*;
    logic  valid;
    logic  ready;
    t_item item;
    modport source (output valid, output item, input ready);
    modport sink   (input valid, input item, output ready);
endinterface

interface bspm_result_if;
    import bspm_pkg::*;
    logic    valid;
    logic    ready;
    t_result result;
    modport source (output valid, output result, input ready);
    modport sink   (input valid, input result, output ready);
endinterface

interface bspm_cfg_if;
    import bspm_pkg::*;
    logic              valid;
    logic              ready;
    logic [CFG_IW-1:0] index;
    logic [CFG_DW-1:0] data;
    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

// ===== src/buffer_slot_pin_manager.sv =====
`timescale 1ns / 1ps
// Buffer slot pin manager: binds inner tree nodes to a pool of vector slots.
// Depends on bspm_pkg and the channel interfaces in bspm_ifs.sv.
//
//  Channel  | Direction | Handshake     | Payload
//  ---------+-----------+---------------+------------------------------------
//  i_in     | in        | valid / ready | kind, node, cost
//  o_out    | out       | valid / ready | slot, flags, evicted node, max slot
//  i_cfg    | in        | valid / ready | register index, write data
//
//  One request is worked on at a time; the result sits in an output register, so a new
//  request is taken while the previous result still waits. Acquire of a held node, release,
//  set cost and query need no search; acquire of an unpinned node adds a free-slot search
//  over num_slots entries and, if none is free, an eviction scan over the inner nodes (one
//  node-table entry per cycle, pipelined reads). Unpin all walks the slots; clear costs, save
//  and restore (with snapshots enabled) walk every entry of both tables.
//  After reset a clearing pass writes both tables with i_in.ready low; register writes are
//  always taken (i_cfg.ready is tied high).
module buffer_slot_pin_manager (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    bspm_item_if.sink            i_in,
    bspm_result_if.source        o_out,
    bspm_cfg_if.sink             i_cfg
);
    import bspm_pkg::*;

    // Tables: node word per inner node, slot word per slot, each with a shadow copy
    t_node_word node_mem [MAX_TIPS];
    t_slot_word slot_mem [MAX_SLOTS];

    t_node_word         r_nrd;
    t_slot_word         r_srd;
    logic               node_we;
    logic [NODE_AW-1:0] node_waddr;
    logic [NODE_AW-1:0] node_raddr;
    t_node_word         node_wdata;
    logic               slot_we;
    logic [SLOT_AW-1:0] slot_waddr;
    logic [SLOT_AW-1:0] slot_raddr;
    t_slot_word         slot_wdata;

    // Configuration
    logic [TIPS_W-1:0]  r_num_tips;
    logic [SLOTS_W-1:0] r_num_slots;
    logic               r_snap_en;
    logic [TIPS_W-1:0]  nt;
    logic [SLOTS_W-1:0] ns;
    logic [TIPS_W-1:0]  ninner;

    // Control
    t_state             r_state, n_state;
    t_sweep_op          r_sw_op, n_sw_op;
    logic [SWEEP_W-1:0] r_cnt, n_cnt;
    logic               r_wv, n_wv;
    logic [SWEEP_W-1:0] r_wi, n_wi;
    logic               r_all_busy, n_all_busy;
    logic               r_sh_all_busy, n_sh_all_busy;
    logic [SLOT_AW-1:0] r_highest, n_highest;
    logic               r_ov, n_ov;
    t_result            r_out, n_out;

    // Request in progress
    logic [KIND_W-1:0]  r_kind, n_kind;
    logic [NODE_AW-1:0] r_idx, n_idx;
    logic [COST_W-1:0]  r_cost, n_cost;
    t_node_word         r_nword, n_nword;
    t_slot_word         r_sword, n_sword;
    logic [SLOT_AW-1:0] r_tslot, n_tslot;
    logic [SLOT_AW-1:0] r_pick, n_pick;
    logic [BEST_W-1:0]  r_best, n_best;
    logic               r_found, n_found;

    // Free-slot search and eviction scan pipelines
    logic [SLOT_AW:0]   r_ri, n_ri;
    logic               r_fv, n_fv;
    logic [SLOT_AW-1:0] r_fi, n_fi;
    logic [TIPS_W-1:0]  r_ei, n_ei;
    logic               r_e1v, n_e1v;
    logic               r_e2v, n_e2v;
    logic [COST_W-1:0]  r_e2cost, n_e2cost;
    logic [SLOT_AW-1:0] r_e2slot, n_e2slot;

    // Unpin-all walk
    logic [SLOT_AW:0]   r_ui, n_ui;
    logic [NODE_AW-1:0] r_own, n_own;

    // Result being built
    logic [SLOT_AW-1:0] r_res_slot, n_res_slot;
    logic               r_need, n_need;
    logic               r_pin, n_pin;
    logic               r_ev, n_ev;
    logic [NODE_W-1:0]  r_evn, n_evn;
    logic               r_err, n_err;

    // Request decode
    logic               in_fire;
    logic [NODE_W:0]    in_node_x;
    logic [NODE_W:0]    two_nt_m2;
    logic               in_inner;
    logic               in_tip;
    logic [NODE_AW-1:0] in_idx;
    logic               in_cost_bad;

    // Step decisions
    logic               map_in_range;
    logic               free_hit;
    logic               free_miss;
    logic               ev_take;
    logic               ev_bad;
    logic               ev_better;
    logic               ev_stop;
    logic               ev_end;
    logic               out_free;
    logic               sweep_end;

    // Effective configuration: clamp to the supported ranges
    always_comb begin
        if (r_num_tips < TIPS_W'(4)) begin
            nt = TIPS_W'(4);
        end else if (r_num_tips > TIPS_W'(MAX_TIPS)) begin
            nt = TIPS_W'(MAX_TIPS);
        end else begin
            nt = r_num_tips;
        end
        if (r_num_slots < SLOTS_W'(1)) begin
            ns = SLOTS_W'(1);
        end else if (r_num_slots > SLOTS_W'(MAX_SLOTS)) begin
            ns = SLOTS_W'(MAX_SLOTS);
        end else begin
            ns = r_num_slots;
        end
    end
    assign ninner = nt - TIPS_W'(2);

    assign in_fire     = i_in.valid && i_in.ready;
    assign in_node_x   = {1'b0, i_in.item.node};
    assign two_nt_m2   = {nt, 1'b0} - (NODE_W + 1)'(2);
    assign in_tip      = in_node_x <= {1'b0, nt};
    assign in_inner    = !in_tip && (in_node_x <= two_nt_m2);
    assign in_idx      = NODE_AW'(i_in.item.node - nt - NODE_W'(1));
    assign in_cost_bad = (i_in.item.cost < CHEAPEST_COST)
                      || (TIPS_W'(i_in.item.cost) > (nt - TIPS_W'(1)));

    // Inner nodes pinned to a slot beyond num_slots are ignored by release and eviction
    assign map_in_range = SLOTS_W'(r_nrd.map) < ns;

    assign free_hit  = r_fv && !r_srd.valid;
    assign free_miss = !r_fv && (r_ri >= (SLOT_AW + 1)'(ns));

    assign ev_take   = r_e2v && r_srd.rel;
    assign ev_bad    = ev_take && (r_e2cost == COST_UNSET);
    assign ev_better = ev_take && !ev_bad && (BEST_W'(r_e2cost) < r_best);
    assign ev_stop   = ev_better && (r_e2cost == CHEAPEST_COST);
    assign ev_end    = !r_e1v && !r_e2v && (r_ei >= ninner);

    assign out_free  = !r_ov || o_out.ready;
    assign sweep_end = (r_cnt == SWEEP_W'(SWEEP_N)) && !r_wv;

    assign i_in.ready   = (r_state == ST_IDLE);
    assign i_cfg.ready  = 1'b1;
    assign o_out.valid  = r_ov;
    assign o_out.result = r_out;

    // Next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (in_fire) begin
                    case (i_in.item.kind)
                        KIND_ACQUIRE, KIND_SETCOST, KIND_QUERY: begin
                            if (!in_inner || ((i_in.item.kind == KIND_SETCOST) && in_cost_bad)) begin
                                n_state = ST_DONE;
                            end else begin
                                n_state = ST_NODE_CHK;
                            end
                        end
                        KIND_RELEASE: begin
                            n_state = in_inner ? ST_NODE_CHK : ST_DONE;
                        end
                        KIND_CLRCOST: n_state = ST_SWEEP;
                        KIND_UNPIN:   n_state = ST_UP_RD;
                        KIND_SAVE, KIND_RESTORE: begin
                            n_state = r_snap_en ? ST_SWEEP : ST_DONE;
                        end
                        default: n_state = ST_DONE;
                    endcase
                end
            end
            ST_SWEEP: begin
                if (sweep_end) begin
                    n_state = (r_sw_op == SW_INIT) ? ST_IDLE : ST_DONE;
                end
            end
            ST_NODE_CHK: begin
                case (r_kind)
                    KIND_ACQUIRE: begin
                        if (!r_nrd.map.unpinned) begin
                            n_state = ST_SLOT_WR;
                        end else if (!r_all_busy) begin
                            n_state = ST_FREE;
                        end else begin
                            n_state = ST_EVICT;
                        end
                    end
                    KIND_RELEASE: n_state = map_in_range ? ST_SLOT_WR : ST_DONE;
                    default:      n_state = ST_DONE;
                endcase
            end
            ST_SLOT_WR: n_state = ST_DONE;
            ST_FREE: begin
                if (free_hit) begin
                    n_state = ST_PIN;
                end else if (free_miss) begin
                    n_state = ST_EVICT;
                end
            end
            ST_EVICT: begin
                if (ev_bad) begin
                    n_state = ST_DONE;
                end else if (ev_stop) begin
                    n_state = ST_VIC_RD;
                end else if (ev_end) begin
                    n_state = r_found ? ST_VIC_RD : ST_DONE;
                end
            end
            ST_VIC_RD:  n_state = r_sword.valid ? ST_VIC_WR : ST_PIN;
            ST_VIC_WR:  n_state = ST_PIN;
            ST_PIN:     n_state = ST_DONE;
            ST_UP_RD:   n_state = (r_ui < (SLOT_AW + 1)'(ns)) ? ST_UP_OWN : ST_DONE;
            ST_UP_OWN:  n_state = r_srd.valid ? ST_UP_NODE : ST_UP_RD;
            ST_UP_NODE: n_state = ST_UP_RD;
            ST_DONE:    n_state = out_free ? ST_IDLE : ST_DONE;
            default:    n_state = ST_IDLE;
        endcase
    end

    // Datapath, table access and result
    always_comb begin
        n_sw_op       = r_sw_op;
        n_cnt         = r_cnt;
        n_wv          = r_wv;
        n_wi          = r_wi;
        n_all_busy    = r_all_busy;
        n_sh_all_busy = r_sh_all_busy;
        n_highest     = r_highest;
        n_ov          = r_ov;
        n_out         = r_out;
        n_kind        = r_kind;
        n_idx         = r_idx;
        n_cost        = r_cost;
        n_nword       = r_nword;
        n_sword       = r_sword;
        n_tslot       = r_tslot;
        n_pick        = r_pick;
        n_best        = r_best;
        n_found       = r_found;
        n_ri          = r_ri;
        n_fv          = r_fv;
        n_fi          = r_fi;
        n_ei          = r_ei;
        n_e1v         = r_e1v;
        n_e2v         = r_e2v;
        n_e2cost      = r_e2cost;
        n_e2slot      = r_e2slot;
        n_ui          = r_ui;
        n_own         = r_own;
        n_res_slot    = r_res_slot;
        n_need        = r_need;
        n_pin         = r_pin;
        n_ev          = r_ev;
        n_evn         = r_evn;
        n_err         = r_err;

        node_we    = 1'b0;
        node_waddr = '0;
        node_raddr = '0;
        node_wdata = r_nrd;
        slot_we    = 1'b0;
        slot_waddr = '0;
        slot_raddr = '0;
        slot_wdata = r_srd;

        // Result register: free it as soon as the consumer takes it
        if (r_ov && o_out.ready) begin
            n_ov = 1'b0;
        end

        case (r_state)
            ST_IDLE: begin
                node_raddr = in_idx;
                if (in_fire) begin
                    n_kind     = i_in.item.kind;
                    n_idx      = in_idx;
                    n_cost     = i_in.item.cost;
                    n_res_slot = '0;
                    n_need     = 1'b0;
                    n_pin      = 1'b0;
                    n_ev       = 1'b0;
                    n_evn      = '0;
                    n_err      = 1'b0;
                    n_cnt      = '0;
                    n_wv       = 1'b0;
                    n_ui       = '0;
                    case (i_in.item.kind)
                        KIND_ACQUIRE, KIND_QUERY: n_err = !in_inner;
                        KIND_SETCOST:             n_err = !in_inner || in_cost_bad;
                        KIND_RELEASE:             n_err = !in_tip && !in_inner;
                        KIND_CLRCOST:             n_sw_op = SW_CLRCOST;
                        KIND_SAVE: begin
                            n_sw_op = SW_SAVE;
                            if (r_snap_en) begin
                                n_sh_all_busy = r_all_busy;
                            end
                        end
                        KIND_RESTORE: begin
                            n_sw_op = SW_RESTORE;
                            if (r_snap_en) begin
                                n_all_busy = r_sh_all_busy;
                            end
                        end
                        default: n_err = 1'b0;
                    endcase
                end
            end
            ST_SWEEP: begin
                // Read entry r_cnt, write back the entry read in the previous cycle
                node_raddr = r_cnt[NODE_AW-1:0];
                slot_raddr = r_cnt[SLOT_AW-1:0];
                if (r_cnt < SWEEP_W'(SWEEP_N)) begin
                    n_cnt = r_cnt + SWEEP_W'(1);
                    n_wv  = 1'b1;
                    n_wi  = r_cnt;
                end else begin
                    n_wv = 1'b0;
                end
                node_waddr = r_wi[NODE_AW-1:0];
                slot_waddr = r_wi[SLOT_AW-1:0];
                case (r_sw_op)
                    SW_INIT: begin
                        node_wdata            = '0;
                        node_wdata.map        = MAP_NONE;
                        node_wdata.shadow_map = MAP_NONE;
                        slot_wdata            = '0;
                        node_we = r_wv && (r_wi < SWEEP_W'(MAX_TIPS));
                        slot_we = r_wv && (r_wi < SWEEP_W'(MAX_SLOTS));
                    end
                    SW_CLRCOST: begin
                        node_wdata.cost = COST_UNSET;
                        node_we = r_wv && (r_wi < SWEEP_W'(MAX_TIPS));
                    end
                    SW_SAVE: begin
                        node_wdata.shadow_map = r_nrd.map;
                        slot_wdata.sh_rel     = r_srd.rel;
                        slot_wdata.sh_valid   = r_srd.valid;
                        slot_wdata.sh_owner   = r_srd.owner;
                        node_we = r_wv && (r_wi < SWEEP_W'(MAX_TIPS));
                        slot_we = r_wv && (r_wi < SWEEP_W'(MAX_SLOTS));
                    end
                    SW_RESTORE: begin
                        node_wdata.map   = r_nrd.shadow_map;
                        slot_wdata.rel   = r_srd.sh_rel;
                        slot_wdata.valid = r_srd.sh_valid;
                        slot_wdata.owner = r_srd.sh_owner;
                        node_we = r_wv && (r_wi < SWEEP_W'(MAX_TIPS));
                        slot_we = r_wv && (r_wi < SWEEP_W'(MAX_SLOTS));
                    end
                    default: begin
                        node_we = 1'b0;
                    end
                endcase
            end
            ST_NODE_CHK: begin
                n_nword    = r_nrd;
                slot_raddr = r_nrd.map.slot;
                n_tslot    = r_nrd.map.slot;
                n_ri       = '0;
                n_fv       = 1'b0;
                n_ei       = '0;
                n_e1v      = 1'b0;
                n_e2v      = 1'b0;
                n_best     = {nt, 1'b0};
                n_found    = 1'b0;
                case (r_kind)
                    KIND_ACQUIRE: begin
                        if (!r_nrd.map.unpinned) begin
                            n_res_slot = r_nrd.map.slot;
                        end
                    end
                    KIND_SETCOST: begin
                        node_we         = 1'b1;
                        node_waddr      = r_idx;
                        node_wdata.cost = r_cost;
                    end
                    KIND_QUERY: begin
                        if (!r_nrd.map.unpinned) begin
                            n_pin      = 1'b1;
                            n_res_slot = r_nrd.map.slot;
                        end
                    end
                    default: n_pin = 1'b0;
                endcase
            end
            ST_SLOT_WR: begin
                // Acquire protects the slot, release marks it free to evict
                slot_we        = 1'b1;
                slot_waddr     = r_tslot;
                slot_wdata.rel = (r_kind == KIND_RELEASE);
            end
            ST_FREE: begin
                slot_raddr = r_ri[SLOT_AW-1:0];
                if (r_ri < (SLOT_AW + 1)'(ns)) begin
                    n_ri = r_ri + (SLOT_AW + 1)'(1);
                    n_fv = 1'b1;
                    n_fi = r_ri[SLOT_AW-1:0];
                end else begin
                    n_fv = 1'b0;
                end
                if (free_hit) begin
                    n_pick  = r_fi;
                    n_sword = r_srd;
                end else if (free_miss) begin
                    n_all_busy = 1'b1;
                end
            end
            ST_EVICT: begin
                // Stage 0: node word read; stage 1: slot word read; stage 2: compare
                node_raddr = r_ei[NODE_AW-1:0];
                slot_raddr = r_nrd.map.slot;
                if (r_ei < ninner) begin
                    n_ei  = r_ei + TIPS_W'(1);
                    n_e1v = 1'b1;
                end else begin
                    n_e1v = 1'b0;
                end
                n_e2v    = r_e1v && map_in_range;
                n_e2cost = r_nrd.cost;
                n_e2slot = r_nrd.map.slot;
                if (ev_bad) begin
                    n_err = 1'b1;
                end else if (ev_better) begin
                    n_best  = BEST_W'(r_e2cost);
                    n_found = 1'b1;
                    n_pick  = r_e2slot;
                    n_sword = r_srd;
                end else if (ev_end && !r_found) begin
                    n_err = 1'b1;
                end
            end
            ST_VIC_RD: begin
                node_raddr = r_sword.owner;
            end
            ST_VIC_WR: begin
                node_we        = 1'b1;
                node_waddr     = r_sword.owner;
                node_wdata.map = MAP_NONE;
                n_ev           = 1'b1;
                n_evn          = NODE_W'(r_sword.owner) + nt + NODE_W'(1);
            end
            ST_PIN: begin
                node_we             = 1'b1;
                node_waddr          = r_idx;
                node_wdata          = r_nword;
                node_wdata.map      = '{unpinned: 1'b0, slot: r_pick};
                slot_we             = 1'b1;
                slot_waddr          = r_pick;
                slot_wdata          = r_sword;
                slot_wdata.rel      = 1'b0;
                slot_wdata.valid    = 1'b1;
                slot_wdata.owner    = r_idx;
                n_res_slot          = r_pick;
                n_need              = 1'b1;
                if (r_pick > r_highest) begin
                    n_highest = r_pick;
                end
            end
            ST_UP_RD: begin
                slot_raddr = r_ui[SLOT_AW-1:0];
            end
            ST_UP_OWN: begin
                slot_we          = 1'b1;
                slot_waddr       = r_ui[SLOT_AW-1:0];
                slot_wdata.valid = 1'b0;
                node_raddr       = r_srd.owner;
                n_own            = r_srd.owner;
                if (!r_srd.valid) begin
                    n_ui = r_ui + (SLOT_AW + 1)'(1);
                end
            end
            ST_UP_NODE: begin
                node_we        = 1'b1;
                node_waddr     = r_own;
                node_wdata.map = MAP_NONE;
                n_ui           = r_ui + (SLOT_AW + 1)'(1);
            end
            ST_DONE: begin
                if (out_free) begin
                    n_ov                  = 1'b1;
                    n_out.slot            = SLOT_W'(r_res_slot);
                    n_out.needs_recompute = r_need;
                    n_out.is_pinned       = r_pin;
                    n_out.evicted         = r_ev;
                    n_out.evicted_node    = r_evn;
                    n_out.max_slot_used   = SLOT_W'(r_highest);
                    n_out.error           = r_err;
                end
            end
            default: begin
                node_we = 1'b0;
            end
        endcase
    end

    // Tables
    always_ff @(posedge i_clk) begin
        if (node_we) begin
            node_mem[node_waddr] <= node_wdata;
        end
        r_nrd <= node_mem[node_raddr];
    end

    always_ff @(posedge i_clk) begin
        if (slot_we) begin
            slot_mem[slot_waddr] <= slot_wdata;
        end
        r_srd <= slot_mem[slot_raddr];
    end

    // Control registers; reset starts the clearing pass
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= ST_SWEEP;
            r_sw_op       <= SW_INIT;
            r_cnt         <= '0;
            r_wv          <= 1'b0;
            r_all_busy    <= 1'b0;
            r_sh_all_busy <= 1'b0;
            r_highest     <= '0;
            r_ov          <= 1'b0;
            r_num_tips    <= TIPS_W'(MAX_TIPS);
            r_num_slots   <= SLOTS_W'(MAX_SLOTS);
            r_snap_en     <= 1'b1;
        end else begin
            r_state       <= n_state;
            r_sw_op       <= n_sw_op;
            r_cnt         <= n_cnt;
            r_wv          <= n_wv;
            r_all_busy    <= n_all_busy;
            r_sh_all_busy <= n_sh_all_busy;
            r_highest     <= n_highest;
            r_ov          <= n_ov;
            if (i_cfg.valid && i_cfg.ready) begin
                case (i_cfg.index)
                    CFG_NUM_TIPS:  r_num_tips  <= i_cfg.data[TIPS_W-1:0];
                    CFG_NUM_SLOTS: r_num_slots <= i_cfg.data[SLOTS_W-1:0];
                    CFG_SNAP_EN:   r_snap_en   <= i_cfg.data[0];
                    default:       r_snap_en   <= r_snap_en;
                endcase
            end
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        r_out      <= n_out;
        r_wi       <= n_wi;
        r_kind     <= n_kind;
        r_idx      <= n_idx;
        r_cost     <= n_cost;
        r_nword    <= n_nword;
        r_sword    <= n_sword;
        r_tslot    <= n_tslot;
        r_pick     <= n_pick;
        r_best     <= n_best;
        r_found    <= n_found;
        r_ri       <= n_ri;
        r_fv       <= n_fv;
        r_fi       <= n_fi;
        r_ei       <= n_ei;
        r_e1v      <= n_e1v;
        r_e2v      <= n_e2v;
        r_e2cost   <= n_e2cost;
        r_e2slot   <= n_e2slot;
        r_ui       <= n_ui;
        r_own      <= n_own;
        r_res_slot <= n_res_slot;
        r_need     <= n_need;
        r_pin      <= n_pin;
        r_ev       <= n_ev;
        r_evn      <= n_evn;
        r_err      <= n_err;
    end

endmodule

// ===== src/bspm_checker.sv =====
`timescale 1ns / 1ps
// Port-level checks on the result channel of the pin manager, and their bind.
// Depends on bspm_pkg and on buffer_slot_pin_manager.
module bspm_checker (
    input logic              i_clk,
    input logic              i_rst_n,
    input logic              i_out_valid,
    input logic              i_out_ready,
    input bspm_pkg::t_result i_out_result
);
    import bspm_pkg::*;

    logic              r_seen;
    logic [SLOT_W-1:0] r_last_max;

    // Track the last delivered high-water mark
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_seen <= 1'b0;
        end else if (i_out_valid && i_out_ready) begin
            r_seen <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_out_valid && i_out_ready) begin
            r_last_max <= i_out_result.max_slot_used;
        end
    end

    a_hold_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid)
        else $error("result withdrawn before it was taken");

    a_max_monotonic: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_out_ready && r_seen |-> i_out_result.max_slot_used >= r_last_max)
        else $error("highest slot went down");

    a_evict_pins: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_out_result.evicted |->
            i_out_result.needs_recompute && !i_out_result.error
            && (i_out_result.slot <= i_out_result.max_slot_used))
        else $error("eviction without a fresh pin");

    a_error_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_out_result.error |->
            !i_out_result.needs_recompute && !i_out_result.is_pinned
            && !i_out_result.evicted && (i_out_result.slot == '0))
        else $error("failed request carries a result");

    a_evicted_node_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_result.evicted |-> i_out_result.evicted_node == '0)
        else $error("evicted node set without an eviction");

endmodule

bind buffer_slot_pin_manager bspm_checker u_bspm_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .i_out_valid  (o_out.valid),
    .i_out_ready  (o_out.ready),
    .i_out_result (o_out.result)
);
